### design/pba_pkg.sv
`default_nettype none

package pba_pkg;

    // Page geometry.
    localparam int          PAGE_SHIFT      = 12;
    localparam logic [11:0] OFFSET_MASK     = 12'hfff;
    localparam logic [12:0] PAGE_BYTES      = 13'h1000;
    localparam int          BITS_PER_WORD   = 32;
    localparam int          BIT_IDX_W       = 5;
    localparam logic [31:0] USABLE_TYPE     = 32'd1;
    localparam logic [31:0] USABLE_BASE_RST = 32'h0010_0000;
    localparam logic [15:0] FREE_PAGES_MAX  = 16'hffff;

    // Page numbers derived from 64-bit byte addresses, with room for a carry.
    localparam int PAGE_NUM_W = 54;

    // Item kinds.
    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] region_base;
        logic [63:0] region_length;
        logic [31:0] region_type;
        logic [31:0] free_address;
    } t_pba_in;

    typedef struct packed {
        logic [31:0] page_address;
        logic [1:0]  status;
        logic [15:0] free_pages;
    } t_pba_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RG_ALIGN,
        ST_RG_SPAN,
        ST_RG_CLAMP,
        ST_RG_START,
        ST_GROW,
        ST_MARK,
        ST_SCAN,
        ST_RESP
    } t_pba_state;

    typedef enum logic {
        ALU_MARK,
        ALU_TAKE
    } t_pba_alu_op;

    typedef struct packed {
        t_pba_alu_op          op;
        logic [BIT_IDX_W-1:0] lo_bit;
        logic [BIT_IDX_W-1:0] hi_bit;
    } t_pba_alu_req;

    typedef struct packed {
        logic [31:0]          new_word;
        logic [5:0]           added;
        logic [BIT_IDX_W-1:0] take_bit;
        logic                 any_set;
    } t_pba_alu_res;

endpackage

`default_nettype wire

### design/page_bitmap_allocator.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_item  (t_pba_in)
// out       output     o_out_valid / i_out_stall  o_out_item (t_pba_out)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (usable_base)
//
// One item is worked on at a time; the input stalls until its result is queued.
// Allocate scans the bitmap words in use in order until one holds a free page.
// Region aligns, spans, clamps and picks its start page, then zeroes new words and marks pages.
// Free marks its page by read-modify-write of one bitmap word; out of range goes straight to the result.
// Reset is synchronous: counts clear and usable_base returns to 0x100000; no map clear.
// A result waits in the output register while the next item is already accepted.
`default_nettype none

module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int MAP_WORDS = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_pba_in  i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_pba_out      o_out_item,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    localparam int WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WUW = $clog2(MAP_WORDS + 1);
    localparam int PIW = WAW + BIT_IDX_W;
    localparam int FCW = $clog2(MAP_WORDS * BITS_PER_WORD + 1);
    localparam logic [PIW:0] CAP_PAGES = (PIW + 1)'(MAP_WORDS * BITS_PER_WORD);

    t_pba_state r_state, n_state;
    t_pba_in    r_item;
    logic [31:0] r_usable_base;
    logic [WUW-1:0] r_wiu;
    logic [FCW-1:0] r_fc;
    logic [63:0] r_len;
    logic [PAGE_NUM_W-1:0] r_first;
    logic [PAGE_NUM_W-1:0] r_end;
    logic [20:0] r_lowu;
    logic [PIW:0] r_endc;
    logic [1:0]  r_status;
    logic [31:0] r_addr;
    logic [WAW-1:0] r_first_word, r_last_word, r_pend_word;
    logic [BIT_IDX_W-1:0] r_lo_bit, r_hi_bit;
    logic r_mark_en;
    logic [WUW-1:0] r_cnt;
    logic r_issue_done;
    logic r_pend;
    logic r_out_valid;
    t_pba_out r_out;

    logic        accept;
    logic [19:0] fr_page;
    logic [14:0] fr_word;
    logic        fr_ok;
    logic [11:0] a_off;
    logic [12:0] a_gap;
    logic        a_skip;
    logic [51:0] s_count;
    logic        c_over;
    logic [PIW:0] c_endc;
    logic        c_empty;
    logic [PAGE_NUM_W-1:0] st_ps;
    logic [PIW:0] st_last;
    logic        st_mark;
    logic        g_more;
    logic        m_issue, m_done;
    logic        sc_issue, sc_found, sc_empty;
    logic        out_free;
    logic [PIW+11:0] take_addr;
    logic [15:0] fc_sat;

    logic           ram_we, ram_re;
    logic [WAW-1:0] ram_waddr, ram_raddr;
    logic [31:0]    ram_wdata, ram_rdata;
    t_pba_alu_req   alu_req;
    t_pba_alu_res   alu_res;

    pba_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WAW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pba_word_alu u_alu (
        .i_req  (alu_req),
        .i_word (ram_rdata),
        .o_res  (alu_res)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Decode of a free item straight from the input.
    assign fr_page = i_in_item.free_address[31:PAGE_SHIFT];
    assign fr_word = fr_page[19:BIT_IDX_W];
    assign fr_ok   = 32'(fr_word) < 32'(r_wiu);

    // Region set-up: alignment, page span, clamping and start page, one per cycle.
    always_comb begin
        a_off   = r_item.region_base[11:0] & OFFSET_MASK;
        a_gap   = PAGE_BYTES - {1'b0, a_off};
        a_skip  = (a_off != '0) && (64'(a_gap) >= r_item.region_length);
        s_count = r_len[63:PAGE_SHIFT];
        c_over  = r_end > PAGE_NUM_W'(CAP_PAGES);
        c_endc  = c_over ? CAP_PAGES : r_end[PIW:0];
        c_empty = r_first >= PAGE_NUM_W'(c_endc);
        st_ps   = (r_first > PAGE_NUM_W'(r_lowu)) ? r_first : PAGE_NUM_W'(r_lowu);
        st_last = r_endc - 1'b1;
        st_mark = (r_item.region_type == USABLE_TYPE) && (st_ps < PAGE_NUM_W'(r_endc));
        g_more  = r_wiu <= WUW'(r_last_word);
    end

    // Word walk conditions for marking and scanning.
    always_comb begin
        m_issue  = !r_issue_done;
        m_done   = r_pend && (r_pend_word == r_last_word);
        sc_found = r_pend && alu_res.any_set;
        sc_issue = (r_cnt < r_wiu) && !sc_found;
        sc_empty = !r_pend && !(r_cnt < r_wiu);
    end

    assign take_addr = {r_pend_word, alu_res.take_bit, 12'h000};
    assign fc_sat    = (32'(r_fc) > 32'(FREE_PAGES_MAX)) ? FREE_PAGES_MAX : 16'(r_fc);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_item.kind)
                        KIND_REGION: n_state = ST_RG_ALIGN;
                        KIND_ALLOC:  n_state = ST_SCAN;
                        KIND_FREE:   n_state = fr_ok ? ST_MARK : ST_RESP;
                        default:     n_state = ST_RESP;
                    endcase
                end
            end
            ST_RG_ALIGN: n_state = a_skip ? ST_RESP : ST_RG_SPAN;
            ST_RG_SPAN:  n_state = (s_count == '0) ? ST_RESP : ST_RG_CLAMP;
            ST_RG_CLAMP: n_state = c_empty ? ST_RESP : ST_RG_START;
            ST_RG_START: n_state = ST_GROW;
            ST_GROW: begin
                if (!g_more) begin
                    n_state = r_mark_en ? ST_MARK : ST_RESP;
                end
            end
            ST_MARK: begin
                if (m_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_SCAN: begin
                if (sc_found || sc_empty) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory and word unit controls.
    always_comb begin
        ram_we         = 1'b0;
        ram_waddr      = r_pend_word;
        ram_wdata      = alu_res.new_word;
        ram_re         = 1'b0;
        ram_raddr      = r_cnt[WAW-1:0];
        alu_req.op     = ALU_MARK;
        alu_req.lo_bit = (r_pend_word == r_first_word) ? r_lo_bit : '0;
        alu_req.hi_bit = (r_pend_word == r_last_word) ? r_hi_bit : 5'd31;
        case (r_state)
            ST_GROW: begin
                ram_we    = g_more;
                ram_waddr = r_wiu[WAW-1:0];
                ram_wdata = '0;
            end
            ST_MARK: begin
                ram_re = m_issue;
                ram_we = r_pend;
            end
            ST_SCAN: begin
                alu_req.op = ALU_TAKE;
                ram_re     = sc_issue;
                ram_we     = sc_found;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_usable_base <= USABLE_BASE_RST;
            r_wiu         <= '0;
            r_fc          <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_usable_base <= i_cfg_data;
            end
            if (r_state == ST_GROW && g_more) begin
                r_wiu <= r_wiu + 1'b1;
            end
            if (r_state == ST_MARK && r_pend) begin
                r_fc <= r_fc + FCW'(alu_res.added);
            end else if (r_state == ST_SCAN && sc_found) begin
                r_fc <= r_fc - 1'b1;
            end
            case (r_state)
                ST_MARK: r_pend <= m_issue;
                ST_SCAN: r_pend <= sc_issue;
                default: r_pend <= 1'b0;
            endcase
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_item       <= i_in_item;
                    r_addr       <= '0;
                    r_issue_done <= 1'b0;
                    if (i_in_item.kind == KIND_FREE) begin
                        r_cnt        <= WUW'(fr_word);
                        r_first_word <= WAW'(fr_word);
                        r_last_word  <= WAW'(fr_word);
                        r_lo_bit     <= fr_page[BIT_IDX_W-1:0];
                        r_hi_bit     <= fr_page[BIT_IDX_W-1:0];
                        r_status     <= fr_ok ? STAT_OK : STAT_RANGE;
                    end else begin
                        r_cnt    <= '0;
                        r_status <= (i_in_item.kind inside {KIND_REGION, KIND_ALLOC}) ?
                                    STAT_OK : STAT_RANGE;
                    end
                end
            end
            ST_RG_ALIGN: begin
                if (a_off != '0) begin
                    r_len   <= r_item.region_length - 64'(a_gap);
                    r_first <= PAGE_NUM_W'(r_item.region_base[63:PAGE_SHIFT]) + 1'b1;
                end else begin
                    r_len   <= r_item.region_length;
                    r_first <= PAGE_NUM_W'(r_item.region_base[63:PAGE_SHIFT]);
                end
            end
            ST_RG_SPAN: begin
                r_end  <= r_first + PAGE_NUM_W'(s_count);
                r_lowu <= 21'((33'(r_usable_base) + 33'(OFFSET_MASK)) >> PAGE_SHIFT);
            end
            ST_RG_CLAMP: begin
                r_endc   <= c_endc;
                r_status <= c_over ? STAT_RANGE : STAT_OK;
            end
            ST_RG_START: begin
                r_last_word  <= st_last[PIW-1:BIT_IDX_W];
                r_hi_bit     <= st_last[BIT_IDX_W-1:0];
                r_first_word <= st_ps[PIW-1:BIT_IDX_W];
                r_lo_bit     <= st_ps[BIT_IDX_W-1:0];
                r_mark_en    <= st_mark;
            end
            ST_GROW: begin
                r_cnt        <= WUW'(r_first_word);
                r_issue_done <= 1'b0;
            end
            ST_MARK: begin
                if (m_issue) begin
                    r_pend_word  <= r_cnt[WAW-1:0];
                    r_cnt        <= r_cnt + 1'b1;
                    r_issue_done <= (r_cnt[WAW-1:0] == r_last_word);
                end
            end
            ST_SCAN: begin
                if (sc_issue) begin
                    r_pend_word <= r_cnt[WAW-1:0];
                    r_cnt       <= r_cnt + 1'b1;
                end
                if (sc_found) begin
                    r_addr <= 32'(take_addr);
                end else if (sc_empty) begin
                    r_status <= STAT_NO_FREE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    r_out.page_address <= r_addr;
                    r_out.status       <= r_status;
                    r_out.free_pages   <= fc_sat;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // The words in use never pass the map size.
    a_wiu_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wiu <= WUW'(MAP_WORDS))
        else $error("words in use beyond the map size");

    // The free count never exceeds the bits held in the words in use.
    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fc) <= (32'(r_wiu) << BIT_IDX_W))
        else $error("free count larger than the bits in use");

    // Read-modify-write only touches words already in use.
    a_rmw_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != ST_GROW) |-> (32'(ram_waddr) < 32'(r_wiu)))
        else $error("bitmap write outside the words in use");

    // A finished result waits while the output register is still occupied.
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_out_valid && i_out_stall) |=> (r_state == ST_RESP))
        else $error("result dropped while output was stalled");

endmodule

`default_nettype wire

### design/pba_map_ram.sv
`default_nettype none

module pba_map_ram
    import pba_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/pba_word_alu.sv
`default_nettype none

module pba_word_alu
    import pba_pkg::*;
(
    input  wire t_pba_alu_req i_req,
    input  wire logic [31:0]  i_word,
    output t_pba_alu_res      o_res
);

    logic [31:0]          mask;
    logic [31:0]          fresh;
    logic [5:0]           added;
    logic [BIT_IDX_W-1:0] take_bit;

    // Bit range lo..hi of the word, and the bits in it that are not yet free.
    always_comb begin
        mask  = (32'hffff_ffff << i_req.lo_bit) &
                (32'hffff_ffff >> (5'd31 - i_req.hi_bit));
        fresh = mask & ~i_word;
        added = '0;
        for (int i = 0; i < BITS_PER_WORD; i++) begin
            added = added + 6'(fresh[i]);
        end
    end

    // Lowest set bit of the word.
    always_comb begin
        take_bit = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                take_bit = BIT_IDX_W'(i);
            end
        end
    end

    // Merged word for the requested operation.
    always_comb begin
        o_res.added    = added;
        o_res.take_bit = take_bit;
        o_res.any_set  = |i_word;
        case (i_req.op)
            ALU_MARK: o_res.new_word = i_word | mask;
            ALU_TAKE: o_res.new_word = i_word & ~(32'd1 << take_bit);
            default:  o_res.new_word = i_word;
        endcase
    end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pba_pkg::*;

    localparam int          MAP_WORDS    = 1024;
    localparam logic [63:0] MAP_PAGES    = 64'(MAP_WORDS * BITS_PER_WORD);
    localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
    // Longest item: region setup plus zeroing and marking every word.
    localparam int          DRAIN_CYCLES = 2 * MAP_WORDS + 200;
    localparam int          CYCLE_LIMIT  = 6_000_000;
    localparam int          RANDOM_ITEMS = 115;
    localparam int          REPORT_MAX   = 10;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_pba_in     in_item = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_pba_out    o_out_item;
    logic        o_cfg_ready;

    // Predicted state of the allocator.
    logic [31:0] free_map [MAP_WORDS];
    int unsigned words_used = 0;
    int unsigned free_total = 0;
    logic [31:0] usable_floor = USABLE_BASE_RST;

    t_pba_in     queued_items[$];
    t_pba_out    pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int unsigned cycle_count = 0;

    // Sender and receiver pacing.
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    page_bitmap_allocator #(
        .MAP_WORDS(MAP_WORDS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item(o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Extend the words in use so that the given word is covered; new words start empty.
    function automatic void grow_map(logic [63:0] word);
        while (words_used <= word && words_used < MAP_WORDS) begin
            free_map[words_used] = '0;
            words_used++;
        end
    endfunction

    // Set the bit of one page, counting it only if it was not free already.
    function automatic void set_page_free(logic [63:0] page);
        logic [63:0] word;
        logic [4:0]  bit_idx;
        word    = page / BITS_PER_WORD;
        bit_idx = page[4:0];
        if (word < words_used && !free_map[word][bit_idx]) begin
            free_map[word][bit_idx] = 1'b1;
            free_total++;
        end
    endfunction

    // Take in a memory-map region: round the base up, keep whole pages within capacity.
    function automatic logic [1:0] add_region(t_pba_in item);
        logic [63:0] first;
        logic [63:0] offset;
        logic [63:0] gap;
        logic [63:0] length;
        logic [63:0] count;
        logic [63:0] stop;
        logic [63:0] lowest;
        logic [63:0] page;
        logic [1:0]  status;
        status = STAT_OK;
        length = item.region_length;
        first  = item.region_base >> PAGE_SHIFT;
        offset = item.region_base & 64'(OFFSET_MASK);
        if (offset != 0) begin
            gap = 64'(PAGE_BYTES) - offset;
            if (gap >= length) begin
                return STAT_OK;
            end
            length = length - gap;
            first  = first + 1;
        end
        count = length >> PAGE_SHIFT;
        if (count == 0) begin
            return STAT_OK;
        end
        stop = first + count;
        if (stop > MAP_PAGES) begin
            status = STAT_RANGE;
            stop   = MAP_PAGES;
        end
        if (first >= stop) begin
            return status;
        end
        grow_map((stop - 1) / BITS_PER_WORD);
        if (item.region_type != USABLE_TYPE) begin
            return status;
        end
        lowest = ({32'd0, usable_floor} + 64'(OFFSET_MASK)) >> PAGE_SHIFT;
        for (page = (first > lowest) ? first : lowest; page < stop; page++) begin
            set_page_free(page);
        end
        return status;
    endfunction

    // Work out the result of one accepted item and update the predicted state.
    function automatic t_pba_out predict_result(t_pba_in item);
        t_pba_out    res;
        logic        found;
        logic [19:0] page;
        res   = '0;
        found = 1'b0;
        case (item.kind)
            KIND_REGION: begin
                res.status = add_region(item);
            end
            KIND_ALLOC: begin
                for (int w = 0; w < int'(words_used) && !found; w++) begin
                    for (int b = 0; b < BITS_PER_WORD && !found; b++) begin
                        if (free_map[w][b]) begin
                            free_map[w][b]   = 1'b0;
                            free_total--;
                            res.page_address = 32'((w * BITS_PER_WORD + b) << PAGE_SHIFT);
                            found            = 1'b1;
                        end
                    end
                end
                res.status = found ? STAT_OK : STAT_NO_FREE;
            end
            KIND_FREE: begin
                page = item.free_address[31:PAGE_SHIFT];
                if (page / BITS_PER_WORD >= words_used) begin
                    res.status = STAT_RANGE;
                end else begin
                    set_page_free(64'(page));
                end
            end
            default: begin
                res.status = STAT_RANGE;
            end
        endcase
        res.free_pages = (free_total > FREE_PAGES_MAX) ? FREE_PAGES_MAX : free_total[15:0];
        return res;
    endfunction

    function automatic t_pba_in make_item(logic [1:0] kind, logic [63:0] base,
                                          logic [63:0] length, logic [31:0] rtype,
                                          logic [31:0] address);
        t_pba_in item;
        item.kind          = kind;
        item.region_base   = base;
        item.region_length = length;
        item.region_type   = rtype;
        item.free_address  = address;
        return item;
    endfunction

    // Random item: mostly well-formed regions, allocations and releases, some noise.
    function automatic t_pba_in random_item();
        t_pba_in     item;
        int unsigned pick;
        int unsigned page;
        item  = make_item(2'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                          $urandom, $urandom);
        pick  = $urandom_range(0, 99);
        page  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4095) : $urandom_range(0, 32767);
        if (pick < 30) begin
            item.kind        = KIND_REGION;
            item.region_base = 64'(page) << PAGE_SHIFT;
            if ($urandom_range(0, 3) == 0) begin
                item.region_base[11:0] = 12'($urandom);
            end
            case ($urandom_range(0, 9))
                0, 1:    item.region_length = 64'($urandom_range(0, 32'h3000));
                2:       item.region_length = 64'($urandom_range(1, 2048)) << PAGE_SHIFT;
                default: item.region_length = (64'($urandom_range(1, 64)) << PAGE_SHIFT)
                                              | 64'($urandom_range(0, 4095));
            endcase
            if ($urandom_range(0, 4) != 0) begin
                item.region_type = USABLE_TYPE;
            end
        end else if (pick < 60) begin
            item.kind = KIND_ALLOC;
        end else if (pick < 85) begin
            item.kind = KIND_FREE;
            if ($urandom_range(0, 2) == 0) begin
                page = $urandom_range(0, 2047);
            end
            item.free_address = {20'(page), 12'($urandom)};
        end else if (pick < 95) begin
            // Noise region: arbitrary fields, sometimes a small base with a vast length.
            item.kind = KIND_REGION;
            if ($urandom_range(0, 2) == 0) begin
                item.region_base = 64'($urandom_range(0, 32'h0fff_ffff));
            end
            if ($urandom_range(0, 1) == 0) begin
                item.region_type = USABLE_TYPE;
            end
        end else if (pick < 98) begin
            item.kind = KIND_UNKNOWN;
        end else begin
            item.kind = KIND_FREE;
        end
        return item;
    endfunction

    // Write usable_base through the configuration channel.
    task automatic write_usable_base(input logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        usable_floor = value;
        cfg_valid   <= 1'b0;
    endtask

    task automatic wait_until_quiet();
        while (queued_items.size() != 0 || in_valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: takes items from the queue in bursts with random gaps in between.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) begin
                pending_results.push_back(predict_result(in_item));
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (queued_items.size() != 0) begin
                in_item  <= queued_items.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern changes every so often; one long hold-off fills the block.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 600;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_pba_out want;
        if (rst_n && o_out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: address %h status %0d free %0d",
                             o_out_item.page_address, o_out_item.status,
                             o_out_item.free_pages);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.page_address !== want.page_address
                        || o_out_item.status !== want.status
                        || o_out_item.free_pages !== want.free_pages) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("result mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                 want.page_address, want.status, want.free_pages,
                                 o_out_item.page_address, o_out_item.status,
                                 o_out_item.free_pages);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [31:0] floors [4];
        floors[0] = 32'h0000_0000;
        floors[1] = 32'hffff_ffff;
        floors[2] = 32'h0001_2345;
        floors[3] = $urandom;

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items with usable_base at its reset value.
        queued_items.push_back(make_item(KIND_ALLOC, '0, '0, '0, '0));
        queued_items.push_back(make_item(KIND_FREE, '0, '0, '0, 32'h0000_0000));
        queued_items.push_back(make_item(KIND_UNKNOWN, '0, '0, '0, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'h0, 64'h20_0000, USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'h20_0000, 64'h1_0000, 32'd2, '0));
        // Region shorter than its alignment gap, then one with no whole page.
        queued_items.push_back(make_item(KIND_REGION, 64'h30_0001, 64'hfff, USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'h30_0000, 64'hfff, USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'h30_0800, 64'h2800, USABLE_TYPE, '0));
        // Regions reaching past capacity, partly and wholly.
        queued_items.push_back(make_item(KIND_REGION, 64'h7ff_0000, 64'h10_0000,
                                         USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'hffff_ffff_ffff_f000, 64'h2000,
                                         USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_REGION, '1, '1, '1, '1));
        queued_items.push_back(make_item(KIND_ALLOC, '0, '0, '0, '0));
        queued_items.push_back(make_item(KIND_ALLOC, '0, '0, '0, '0));
        // Unaligned release, then releasing a page that is already free.
        queued_items.push_back(make_item(KIND_FREE, '0, '0, '0, 32'h0010_0abc));
        queued_items.push_back(make_item(KIND_FREE, '0, '0, '0, 32'h0010_0000));
        queued_items.push_back(make_item(KIND_FREE, '0, '0, '0, 32'hffff_ffff));
        queued_items.push_back(make_item(KIND_FREE, '0, '0, '0, 32'h0000_5000));
        queued_items.push_back(make_item(KIND_ALLOC, '0, '0, '0, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'h40_0000, 64'h0, USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_REGION, 64'h0, 64'h800_0000, USABLE_TYPE, '0));
        queued_items.push_back(make_item(KIND_ALLOC, '1, '1, '1, '1));
        queued_items.push_back(make_item(KIND_UNKNOWN, '1, '1, '1, '1));
        for (int n = 0; n < RANDOM_ITEMS - 15; n++) begin
            queued_items.push_back(random_item());
        end

        // Further phases, each under another usable_base.
        for (int ph = 0; ph < 4; ph++) begin
            wait_until_quiet();
            repeat (4) @(posedge i_clk);
            write_usable_base(floors[ph]);
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                queued_items.push_back(random_item());
            end
        end

        wait_until_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
